// ===== src/fpa_pkg.sv =====
// Shared types and constants of the Q24.8 fixed-point ALU.
package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int OP_BITS   = 4;

  localparam logic [OP_BITS-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_BITS-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_BITS-1:0] OP_MUL      = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DIV      = 4'd3;
  localparam logic [OP_BITS-1:0] OP_MIN      = 4'd4;
  localparam logic [OP_BITS-1:0] OP_MAX      = 4'd5;
  localparam logic [OP_BITS-1:0] OP_INC      = 4'd6;
  localparam logic [OP_BITS-1:0] OP_DEC      = 4'd7;
  localparam logic [OP_BITS-1:0] OP_FROM_INT = 4'd8;
  localparam logic [OP_BITS-1:0] OP_TO_INT   = 4'd9;

  typedef struct packed {
    logic [OP_BITS-1:0]          req_type;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_value;
    logic                        a_greater;
    logic                        a_less;
    logic                        a_equal;
    logic                        divide_by_zero;
  } alu_out_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [WORD_BITS-1:0] value;
    logic                 gt;
    logic                 lt;
    logic                 eq;
    logic                 dz;
  } side_t;

endpackage

// ===== src/fixed_point_q24_8_alu_core.sv =====
// Top level of the pipelined signed Q24.8 fixed-point ALU.
//
// Input channel in_valid/in_ready/in_data carries an opcode and two raw
// operands; output channel out_valid/out_ready/out_data carries the result
// value and the compare and divide-by-zero flags. One result per transfer.
// From the input transfer to out_valid an item passes an input register,
// one divider stage per quotient bit (Q24.8 by default), a sign stage
// and the output register. The multiplier uses three of those stages
// and rides alongside. Throughput is one item per cycle while the
// pipeline is not held; every operation passes the same pipeline so
// results leave in input order.
// All pipeline stages advance together; when the receiver holds
// out_ready low with a result waiting, the whole pipeline holds and
// in_ready falls until the result is taken.
// Synchronous reset clears all valid bits; no item is in flight afterwards.
module fixed_point_q24_8_alu_core
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  alu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output alu_out_t out_data
);

  localparam int DL = WORD_BITS + FRACTION_BITS + 1;
  localparam int ML = DL - 2;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  alu_in_t s0_r;
  logic    v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  logic signed [WORD_BITS-1:0] a, b;
  logic [WORD_BITS-1:0] mag_a, mag_b, to_int_mag;
  logic                 lt, gt, eq, sgn;
  side_t                side_nxt;

  assign a     = s0_r.operand_a;
  assign b     = s0_r.operand_b;
  assign lt    = a < b;
  assign gt    = a > b;
  assign eq    = a == b;
  assign sgn   = a[WORD_BITS-1] ^ b[WORD_BITS-1];
  assign mag_a = a[WORD_BITS-1] ? (WORD_BITS'(0) - a) : a;
  assign mag_b = b[WORD_BITS-1] ? (WORD_BITS'(0) - b) : b;
  assign to_int_mag = mag_a >> FRACTION_BITS;

  always_comb begin
    side_nxt.op = s0_r.req_type;
    side_nxt.gt = gt;
    side_nxt.lt = lt;
    side_nxt.eq = eq;
    side_nxt.dz = (s0_r.req_type == OP_DIV) && (b == '0);
    case (s0_r.req_type)
      OP_ADD:      side_nxt.value = a + b;
      OP_SUB:      side_nxt.value = a - b;
      OP_MIN:      side_nxt.value = lt ? a : b;
      OP_MAX:      side_nxt.value = gt ? a : b;
      OP_INC:      side_nxt.value = a + WORD_BITS'(1);
      OP_DEC:      side_nxt.value = a - WORD_BITS'(1);
      OP_FROM_INT: side_nxt.value = a << FRACTION_BITS;
      OP_TO_INT:   side_nxt.value = a[WORD_BITS-1] ? (WORD_BITS'(0) - to_int_mag)
                                                   : to_int_mag;
      default:     side_nxt.value = '0;
    endcase
  end

  side_t            side_r [DL];
  logic [DL-1:0]    vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DL-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < DL; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [WORD_BITS-1:0]   m_a_r, m_b_r;
  logic                   m_neg_r, m_neg2_r;
  logic [2*WORD_BITS-1:0] m_p_r, m_s;
  logic [WORD_BITS-1:0]   mdl_r [ML];

  assign m_s = m_neg2_r ? ((2*WORD_BITS)'(0) - m_p_r) : m_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r    <= mag_a;
      m_b_r    <= mag_b;
      m_neg_r  <= sgn;
      m_p_r    <= m_a_r * m_b_r;
      m_neg2_r <= m_neg_r;
      mdl_r[0] <= m_s[WORD_BITS+FRACTION_BITS-1:FRACTION_BITS];
      for (int k = 1; k < ML; k++) begin
        mdl_r[k] <= mdl_r[k-1];
      end
    end
  end

  logic [WORD_BITS-1:0] quo;

  fpa_div_pipe #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (mag_a),
    .den (mag_b),
    .neg (sgn),
    .quo (quo)
  );

  side_t    last;
  alu_out_t out_nxt;
  alu_out_t out_r;
  logic     out_valid_r;

  assign last = side_r[DL-1];

  always_comb begin
    out_nxt.a_greater      = last.gt;
    out_nxt.a_less         = last.lt;
    out_nxt.a_equal        = last.eq;
    out_nxt.divide_by_zero = last.dz;
    case (last.op)
      OP_MUL:  out_nxt.result_value = mdl_r[ML-1];
      OP_DIV:  out_nxt.result_value = last.dz ? '0 : quo;
      default: out_nxt.result_value = last.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.divide_by_zero |-> out_r.result_value == '0)
    else $error("divide by zero with nonzero result");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_r.a_greater, out_r.a_less, out_r.a_equal}))
    else $error("compare flags not exclusive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(v0_r))
    else $error("pipeline moved during stall");

endmodule

// ===== src/fpa_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, signed result.
module fpa_div_pipe
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] quo
);

  localparam int STEPS = WORD_BITS + FRACTION_BITS;

  logic [WORD_BITS-1:0] rem_r [STEPS];
  logic [STEPS-1:0]     n_r   [STEPS];
  logic [WORD_BITS-1:0] q_r   [STEPS];
  logic [WORD_BITS-1:0] d_r   [STEPS];
  logic                 neg_r [STEPS];
  logic [WORD_BITS-1:0] quo_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [WORD_BITS-1:0] p_rem;
    logic [STEPS-1:0]     p_n;
    logic [WORD_BITS-1:0] p_q;
    logic [WORD_BITS-1:0] p_d;
    logic                 p_neg;
    logic [WORD_BITS:0]   t;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign p_rem = '0;
      assign p_n   = {num, {FRACTION_BITS{1'b0}}};
      assign p_q   = '0;
      assign p_d   = den;
      assign p_neg = neg;
    end else begin : g_next
      assign p_rem = rem_r[k-1];
      assign p_n   = n_r[k-1];
      assign p_q   = q_r[k-1];
      assign p_d   = d_r[k-1];
      assign p_neg = neg_r[k-1];
    end

    assign t    = {p_rem, p_n[STEPS-1]};
    assign diff = t - {1'b0, p_d};
    assign ge   = (t >= {1'b0, p_d});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[WORD_BITS-1:0] : t[WORD_BITS-1:0];
        n_r[k]   <= {p_n[STEPS-2:0], 1'b0};
        q_r[k]   <= {p_q[WORD_BITS-2:0], ge};
        d_r[k]   <= p_d;
        neg_r[k] <= p_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[STEPS-1] ? (WORD_BITS'(0) - q_r[STEPS-1]) : q_r[STEPS-1];
    end
  end

  assign quo = quo_r;

endmodule
